// ===== hw/rtl/hsvp_pkg.sv =====
package hsvp_pkg;

    localparam int HUE_FRAC_BITS = 4;

    localparam int HUE_W   = 13;
    localparam int SV_W    = 9;
    localparam int ALPHA_W = 8;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;

    localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;

    // Full scale is 2^16 * HUE_SECTOR = 2^(18 + HUE_FRAC_BITS) * 15, and 255 / 15 = 17,
    // so each channel byte is (y * 17) >> SCALE_SHIFT with no rounding error.
    localparam int SCALE_SHIFT = 18 + HUE_FRAC_BITS;
    localparam int SCALE_MUL   = 17;

    localparam int T_W   = $clog2(HUE_SECTOR + 1);
    localparam int C16_W = 2 * SV_W - 1;
    localparam int Y_W   = $clog2(HUE_SECTOR * 65536 + 1);
    localparam int P_W   = Y_W + 5;
    localparam int Q_W   = P_W - SCALE_SHIFT;

    localparam logic [SV_W-1:0] SV_ONE = SV_W'(256);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] SEC_R_Y = 3'd0;
    localparam logic [2:0] SEC_Y_G = 3'd1;
    localparam logic [2:0] SEC_G_C = 3'd2;
    localparam logic [2:0] SEC_C_B = 3'd3;
    localparam logic [2:0] SEC_B_M = 3'd4;
    localparam logic [2:0] SEC_M_R = 3'd5;

    typedef struct packed {
        logic [2:0]         sector;
        logic [T_W-1:0]     t;
        logic [C16_W-1:0]   c16;
        logic [SV_W-1:0]    v;
        logic [ALPHA_W-1:0] alpha;
    } t_cls;

endpackage

// ===== hw/rtl/hsvp_in_if.sv =====
interface hsvp_in_if;
    logic                          valid;
    logic                          ready;
    logic [hsvp_pkg::HUE_W-1:0]    hue;
    logic [hsvp_pkg::SV_W-1:0]     saturation;
    logic [hsvp_pkg::SV_W-1:0]     brightness;
    logic [hsvp_pkg::ALPHA_W-1:0]  alpha_in;

    modport source (output valid, output hue, output saturation, output brightness,
                    output alpha_in, input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  input alpha_in, output ready);
endinterface

// ===== hw/rtl/hsvp_out_if.sv =====
interface hsvp_out_if;
    logic                         valid;
    logic                         ready;
    logic [hsvp_pkg::WORD_W-1:0]  abgr_word;

    modport source (output valid, output abgr_word, input ready);
    modport sink (input valid, input abgr_word, output ready);
endinterface

// ===== hw/rtl/hsvp_front.sv =====
module hsvp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hsvp_in_if.sink        i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output hsvp_pkg::t_cls o_cls
);
    import hsvp_pkg::*;

    logic             r_valid;
    t_cls             r_cls;
    t_cls             n_cls;
    logic             w_take;
    logic [HUE_W-1:0] w_h;
    logic [SV_W-1:0]  w_s;
    logic [SV_W-1:0]  w_v;
    logic [2:0]       w_sec;
    logic [T_W-1:0]   w_f;

    assign i_in.ready = !r_valid || i_ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        w_s = (i_in.saturation > SV_ONE) ? SV_ONE : i_in.saturation;
        w_v = (i_in.brightness > SV_ONE) ? SV_ONE : i_in.brightness;

        if (int'(i_in.hue) >= HUE_FULL) begin
            w_h = HUE_W'(int'(i_in.hue) - HUE_FULL);
        end else begin
            w_h = i_in.hue;
        end

        priority if (int'(w_h) >= 5 * HUE_SECTOR) begin
            w_sec = SEC_M_R;
            w_f   = T_W'(int'(w_h) - 5 * HUE_SECTOR);
        end else if (int'(w_h) >= 4 * HUE_SECTOR) begin
            w_sec = SEC_B_M;
            w_f   = T_W'(int'(w_h) - 4 * HUE_SECTOR);
        end else if (int'(w_h) >= 3 * HUE_SECTOR) begin
            w_sec = SEC_C_B;
            w_f   = T_W'(int'(w_h) - 3 * HUE_SECTOR);
        end else if (int'(w_h) >= 2 * HUE_SECTOR) begin
            w_sec = SEC_G_C;
            w_f   = T_W'(int'(w_h) - 2 * HUE_SECTOR);
        end else if (int'(w_h) >= HUE_SECTOR) begin
            w_sec = SEC_Y_G;
            w_f   = T_W'(int'(w_h) - HUE_SECTOR);
        end else begin
            w_sec = SEC_R_Y;
            w_f   = T_W'(w_h);
        end

        n_cls.sector = w_sec;
        n_cls.t      = w_sec[0] ? (T_W'(HUE_SECTOR) - w_f) : w_f;
        n_cls.c16    = C16_W'(w_s) * C16_W'(w_v);
        n_cls.v      = w_v;
        n_cls.alpha  = i_in.alpha_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cls <= n_cls;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;
endmodule

// ===== hw/rtl/hsvp_queue.sv =====
module hsvp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hsvp_pkg::t_cls i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output hsvp_pkg::t_cls o_data
);
    import hsvp_pkg::*;

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("Queue count missed a transfer in.");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("Queue pointers disagree while empty.");
endmodule

// ===== hw/rtl/hsvp_back.sv =====
module hsvp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hsvp_pkg::t_cls i_cls,
    hsvp_out_if.source     o_out
);
    import hsvp_pkg::*;

    logic                   r_v1;
    logic [Y_W-1:0]         r_yc;
    logic [Y_W-1:0]         r_yx;
    logic [Y_W-1:0]         r_y0;
    logic [2:0]             r_sec;
    logic [ALPHA_W-1:0]     r_alpha;
    logic                   r_v2;
    logic [WORD_W-1:0]      r_word;
    logic [WORD_W-1:0]      n_word;
    logic                   w_adv1;
    logic                   w_adv2;
    logic [C16_W-1:0]       w_m;
    logic [C16_W+T_W-1:0]   w_ct;
    logic [Y_W-1:0]         w_mo;
    logic [BYTE_W-1:0]      w_bc;
    logic [BYTE_W-1:0]      w_bx;
    logic [BYTE_W-1:0]      w_b0;
    logic [BYTE_W-1:0]      w_r;
    logic [BYTE_W-1:0]      w_g;
    logic [BYTE_W-1:0]      w_b;

    function automatic logic [BYTE_W-1:0] to_byte(input logic [Y_W-1:0] y);
        logic [P_W-1:0] p;
        logic [Q_W-1:0] q;
        p = P_W'(y) * P_W'(SCALE_MUL);
        q = Q_W'(p >> SCALE_SHIFT);
        return (q > Q_W'(255)) ? BYTE_W'(255) : BYTE_W'(q);
    endfunction

    assign w_adv2  = !r_v2 || o_out.ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;

    assign w_m  = (C16_W'(i_cls.v) << 8) - i_cls.c16;
    assign w_ct = (C16_W+T_W)'(i_cls.c16) * (C16_W+T_W)'(i_cls.t);
    assign w_mo = Y_W'(w_m) * Y_W'(HUE_SECTOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_yc    <= Y_W'(i_cls.v) * Y_W'(HUE_SECTOR * 256);
            r_yx    <= Y_W'(w_ct) + w_mo;
            r_y0    <= w_mo;
            r_sec   <= i_cls.sector;
            r_alpha <= i_cls.alpha;
        end
    end

    always_comb begin
        w_bc = to_byte(r_yc);
        w_bx = to_byte(r_yx);
        w_b0 = to_byte(r_y0);
        unique case (r_sec)
            SEC_R_Y: begin w_r = w_bc; w_g = w_bx; w_b = w_b0; end
            SEC_Y_G: begin w_r = w_bx; w_g = w_bc; w_b = w_b0; end
            SEC_G_C: begin w_r = w_b0; w_g = w_bc; w_b = w_bx; end
            SEC_C_B: begin w_r = w_b0; w_g = w_bx; w_b = w_bc; end
            SEC_B_M: begin w_r = w_bx; w_g = w_b0; w_b = w_bc; end
            default: begin w_r = w_bc; w_g = w_b0; w_b = w_bx; end
        endcase
        n_word = {r_alpha, w_b, w_g, w_r};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_v1) begin
            r_word <= n_word;
        end
    end

    assign o_out.valid     = r_v2;
    assign o_out.abgr_word = r_word;
endmodule

// ===== hw/rtl/hsv_to_rgb_pack_core.sv =====
// Converts one HSV color plus an alpha byte into a packed 32-bit ABGR word.
// Input channel i_in carries hue in sixteenths of a degree, saturation and
// brightness in Q1.8 where 256 is full scale, and the alpha byte; a transfer
// happens on a rising edge with valid and ready both high. Output channel
// o_out carries abgr_word with alpha in 31..24, blue, green and red below.
// A hue at or above 360 degrees wraps once, and levels above 256 clip to 256.
// The front stage reduces the hue, finds the sector and forms s*v; a
// two-entry queue then feeds a two-stage back end that forms the channel
// levels and the packed word in an output register.
// An input transfer passes the front register, the queue, the back-end stage
// register and the output register before valid on o_out, and the block
// takes one color every cycle while o_out is not stalled.
// When the receiver holds ready low, the output word holds, the back end and
// the queue fill, and i_in.ready drops only once all stages are full.
// Synchronous reset empties every stage and the queue; no output is valid
// until a new color has passed through.
module hsv_to_rgb_pack_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsvp_in_if.sink     i_in,
    hsvp_out_if.source  o_out
);
    import hsvp_pkg::*;

    logic w_f_valid;
    logic w_f_ready;
    t_cls w_f_cls;
    logic w_q_valid;
    logic w_q_ready;
    t_cls w_q_cls;

    hsvp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_cls   (w_f_cls)
    );

    hsvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_cls),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_cls)
    );

    hsvp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_cls   (w_q_cls),
        .o_out   (o_out)
    );
endmodule
